// ----- hdl/cams_pkg.sv -----
// Shared types and constants for the constant-acceleration motion solver.
// No dependencies; the front end, back end, top level and testbench refer to this package.
`default_nettype none

package cams_pkg;

  localparam int CLS_BITS = 3;
  localparam int TOL_BITS = 16;

  localparam logic FUNC_EXTRAP = 1'b0;
  localparam logic FUNC_SOLVE  = 1'b1;

  localparam logic [TOL_BITS-1:0] TOL_RESET = 16'd1;

  // how the back end treats an item
  typedef enum logic [CLS_BITS-1:0] {
    CLS_EXTRAP,
    CLS_AT_TARGET,
    CLS_LINEAR,
    CLS_QUAD,
    CLS_NEVER
  } cls_t;

endpackage

`default_nettype wire

// ----- hdl/cams_fifo.sv -----
// Two-entry queue between the front end and the math pipeline.
// Uses no package items; width set by parameter.
`default_nettype none

module cams_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  logic [WIDTH-1:0] entry [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_data   = entry[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) entry[wr_ptr] <= push_data;
  end

endmodule

`default_nettype wire

// ----- hdl/cams_front.sv -----
// Front end: takes input beats, classifies them and forms operands.
// Depends on cams_pkg (class codes, func codes, tolerance width).
`default_nettype none

module cams_front #(
  parameter int W = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          func,
  input  logic signed [W-1:0]           start_time,
  input  logic signed [W-1:0]           start_pos,
  input  logic signed [W-1:0]           start_vel,
  input  logic signed [W-1:0]           start_acc,
  input  logic signed [W-1:0]           query_time,
  input  logic                          use_given_acc,
  input  logic signed [W-1:0]           given_acc,
  input  logic signed [W-1:0]           target_pos,
  input  logic [cams_pkg::TOL_BITS-1:0] tol,
  output logic                          rec_valid,
  input  logic                          rec_ready,
  output cams_pkg::cls_t                rec_cls,
  output logic [7*W+1:0]                rec_data
);

  logic signed [W:0] delta;
  logic signed [W:0] dtq;
  logic [W:0]        a_ext;
  logic [W:0]        v_ext;
  logic [W:0]        d_abs;
  logic [W:0]        a_abs;
  logic [W:0]        v_abs;
  logic [W:0]        tol_ext;
  logic [W-1:0]      acc_sel;
  logic              d_pos;
  logic              v_pos;
  cams_pkg::cls_t    cls;

  always_comb begin
    delta   = $signed({target_pos[W-1], target_pos}) - $signed({start_pos[W-1], start_pos});
    dtq     = $signed({query_time[W-1], query_time}) - $signed({start_time[W-1], start_time});
    a_ext   = {start_acc[W-1], start_acc};
    v_ext   = {start_vel[W-1], start_vel};
    d_abs   = delta[W] ? ~delta + 1'b1 : delta;
    a_abs   = a_ext[W] ? ~a_ext + 1'b1 : a_ext;
    v_abs   = v_ext[W] ? ~v_ext + 1'b1 : v_ext;
    tol_ext = (W+1)'(tol);
    d_pos   = !delta[W] && (delta != '0);
    v_pos   = !start_vel[W-1] && (start_vel != '0);
    if (func == cams_pkg::FUNC_EXTRAP) begin
      acc_sel = use_given_acc ? given_acc : start_acc;
      cls     = cams_pkg::CLS_EXTRAP;
    end else begin
      acc_sel = start_acc;
      if (d_abs <= tol_ext) begin
        cls = cams_pkg::CLS_AT_TARGET;
      end else if (a_abs <= tol_ext) begin
        // linear motion: needs real speed heading toward the target
        cls = (v_abs > tol_ext && d_pos == v_pos) ? cams_pkg::CLS_LINEAR
                                                  : cams_pkg::CLS_NEVER;
      end else begin
        cls = cams_pkg::CLS_QUAD;
      end
    end
  end

  assign in_ready = !rec_valid || rec_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rec_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      rec_valid <= 1'b1;
    end else if (rec_ready) begin
      rec_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      rec_cls  <= cls;
      rec_data <= {start_time, query_time, start_pos, start_vel, acc_sel, delta, dtq};
    end
  end

endmodule

`default_nettype wire

// ----- hdl/cams_sqrt_pipe.sv -----
// Pipelined floor square root, one result bit per stage, with a side payload.
// Uses no package items.
`default_nettype none

module cams_sqrt_pipe #(
  parameter int XB     = 65,
  parameter int RW     = 33,
  parameter int SIDE_W = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [XB-1:0]     in_x,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [RW-1:0]     out_root,
  output logic [SIDE_W-1:0] out_side
);

  localparam int TW = 2 * RW;

  logic              vld  [RW];
  logic [RW-1:0]     root [RW];
  logic [TW-1:0]     rem  [RW-1];
  logic [SIDE_W-1:0] side [RW];

  genvar i;
  generate
    for (i = 0; i < RW; i++) begin : g_stage
      localparam int B = RW - 1 - i;
      logic              pv;
      logic [RW-1:0]     pr;
      logic [TW-1:0]     prem;
      logic [SIDE_W-1:0] ps;
      logic [TW-1:0]     trial;
      logic              take;

      if (i == 0) begin : g_first
        assign pv   = in_valid;
        assign pr   = '0;
        assign prem = TW'(in_x);
        assign ps   = in_side;
      end else begin : g_next
        assign pv   = vld[i-1];
        assign pr   = root[i-1];
        assign prem = rem[i-1];
        assign ps   = side[i-1];
      end

      // (r + 2^B)^2 - r^2 = r*2^(B+1) + 2^(2B)
      assign trial = (TW'(pr) << (B + 1)) | (TW'(1) << (2 * B));
      assign take  = (prem >= trial);

      always_ff @(posedge clk) begin
        if (rst) begin
          vld[i] <= 1'b0;
        end else if (en) begin
          vld[i] <= pv;
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          side[i] <= ps;
          root[i] <= take ? (pr | (RW'(1) << B)) : pr;
        end
      end

      if (i < RW - 1) begin : g_rem
        always_ff @(posedge clk) begin
          if (en) begin
            rem[i] <= take ? prem - trial : prem;
          end
        end
      end
    end
  endgenerate

  assign out_valid = vld[RW-1];
  assign out_root  = root[RW-1];
  assign out_side  = side[RW-1];

endmodule

`default_nettype wire

// ----- hdl/cams_div_pipe.sv -----
// Pipelined restoring divider: two numerators over one shared divisor,
// one quotient bit per stage, with a side payload. Uses no package items.
`default_nettype none

module cams_div_pipe #(
  parameter int NM     = 50,
  parameter int DW     = 32,
  parameter int SIDE_W = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [NM-1:0]     in_num_a,
  input  logic [NM-1:0]     in_num_b,
  input  logic [DW-1:0]     in_den,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [NM-1:0]     out_quo_a,
  output logic [NM-1:0]     out_quo_b,
  output logic              out_rem_a_nz,
  output logic              out_rem_b_nz,
  output logic [SIDE_W-1:0] out_side
);

  logic              vld  [NM];
  logic [NM-1:0]     qa   [NM];
  logic [NM-1:0]     qb   [NM];
  logic [DW-1:0]     ra   [NM];
  logic [DW-1:0]     rb   [NM];
  logic [SIDE_W-1:0] side [NM];
  logic [DW-1:0]     den  [NM-1];

  genvar i;
  generate
    for (i = 0; i < NM; i++) begin : g_stage
      logic              pv;
      logic [NM-1:0]     pqa;
      logic [NM-1:0]     pqb;
      logic [DW-1:0]     pra;
      logic [DW-1:0]     prb;
      logic [DW-1:0]     pden;
      logic [SIDE_W-1:0] ps;
      logic [DW:0]       rsa;
      logic [DW:0]       rsb;
      logic              gea;
      logic              geb;

      if (i == 0) begin : g_first
        assign pv   = in_valid;
        assign pqa  = in_num_a;
        assign pqb  = in_num_b;
        assign pra  = '0;
        assign prb  = '0;
        assign pden = in_den;
        assign ps   = in_side;
      end else begin : g_next
        assign pv   = vld[i-1];
        assign pqa  = qa[i-1];
        assign pqb  = qb[i-1];
        assign pra  = ra[i-1];
        assign prb  = rb[i-1];
        assign pden = den[i-1];
        assign ps   = side[i-1];
      end

      // numerator bits shift out the top, quotient bits shift in below
      assign rsa = {pra, pqa[NM-1]};
      assign rsb = {prb, pqb[NM-1]};
      assign gea = (rsa >= {1'b0, pden});
      assign geb = (rsb >= {1'b0, pden});

      always_ff @(posedge clk) begin
        if (rst) begin
          vld[i] <= 1'b0;
        end else if (en) begin
          vld[i] <= pv;
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          side[i] <= ps;
          qa[i]   <= {pqa[NM-2:0], gea};
          qb[i]   <= {pqb[NM-2:0], geb};
          ra[i]   <= gea ? DW'(rsa - {1'b0, pden}) : rsa[DW-1:0];
          rb[i]   <= geb ? DW'(rsb - {1'b0, pden}) : rsb[DW-1:0];
        end
      end

      if (i < NM - 1) begin : g_den
        always_ff @(posedge clk) begin
          if (en) begin
            den[i] <= pden;
          end
        end
      end
    end
  endgenerate

  assign out_valid    = vld[NM-1];
  assign out_quo_a    = qa[NM-1];
  assign out_quo_b    = qb[NM-1];
  assign out_rem_a_nz = |ra[NM-1];
  assign out_rem_b_nz = |rb[NM-1];
  assign out_side     = side[NM-1];

endmodule

`default_nettype wire

// ----- hdl/cams_back.sv -----
// Back end: multiplier stages, square root, dividers, root select, output register.
// Depends on cams_pkg, cams_sqrt_pipe and cams_div_pipe.
`default_nettype none

module cams_back #(
  parameter int W = 32,
  parameter int F = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  cams_pkg::cls_t      in_cls,
  input  logic [7*W+1:0]      in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [W-1:0] out_time,
  output logic signed [W-1:0] out_pos,
  output logic signed [W-1:0] out_vel,
  output logic signed [W-1:0] out_acc,
  output logic                reached
);

  localparam int CB     = cams_pkg::CLS_BITS;
  localparam int BIG    = 3 * W + 4;
  localparam int DSW    = 2 * W + 2;
  localparam int QW     = 3 * W + 2;
  localparam int SW     = W + 1;
  localparam int XB     = 2 * W + 1;
  localparam int NS     = W + 3;
  localparam int NM     = W + 2 + F;
  localparam int SIDE_W = CB + 4 * W + 1;
  localparam int SIDE2  = SIDE_W + 2;

  function automatic logic [W-1:0] sat(input logic signed [BIG-1:0] x);
    logic [BIG-W:0] hi;
    hi = x[BIG-1:W-1];
    if (&hi || ~|hi) begin
      sat = x[W-1:0];
    end else begin
      sat = x[BIG-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    end
  endfunction

  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // ---- stage 1: first products
  logic signed [W-1:0] i_t, i_q, i_p, i_vel, i_acc;
  logic signed [W:0]   i_delta, i_dtq;
  logic signed [W:0]   opx, opv;
  logic signed [2*W:0] m1, m2;
  logic signed [DSW-1:0] m3;

  assign {i_t, i_q, i_p, i_vel, i_acc, i_delta, i_dtq} = in_data;

  always_comb begin
    opx = (in_cls == cams_pkg::CLS_EXTRAP) ? i_dtq : i_delta;
    opv = (in_cls == cams_pkg::CLS_EXTRAP) ? i_dtq : $signed({i_vel[W-1], i_vel});
    m1  = i_acc * opx;
    m2  = i_vel * opv;
    m3  = i_dtq * i_dtq;
  end

  logic                  s1_valid;
  cams_pkg::cls_t        s1_cls;
  logic signed [W-1:0]   s1_t, s1_q, s1_p, s1_vel, s1_acc;
  logic signed [W:0]     s1_delta;
  logic signed [2*W:0]   s1_m1, s1_m2;
  logic signed [DSW-1:0] s1_m3;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_cls   <= in_cls;
      s1_t     <= i_t;
      s1_q     <= i_q;
      s1_p     <= i_p;
      s1_vel   <= i_vel;
      s1_acc   <= i_acc;
      s1_delta <= i_delta;
      s1_m1    <= m1;
      s1_m2    <= m2;
      s1_m3    <= m3;
    end
  end

  // ---- stage 2: acc * dt^2 in two halves, velocity, discriminant
  logic [2*W-1:0]        dtsq;
  logic signed [2*W:0]   plo, phi;

  always_comb begin
    dtsq = s1_m3[2*W-1:0];
    plo  = s1_acc * $signed({1'b0, dtsq[W-1:0]});
    phi  = s1_acc * $signed({1'b0, dtsq[2*W-1:W]});
  end

  logic                  s2_valid;
  cams_pkg::cls_t        s2_cls;
  logic signed [W-1:0]   s2_t, s2_q, s2_p, s2_vel, s2_acc, s2_vel_r;
  logic signed [W:0]     s2_delta;
  logic signed [2*W:0]   s2_lin, s2_plo, s2_phi;
  logic signed [DSW-1:0] s2_disc;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_cls   <= s1_cls;
      s2_t     <= s1_t;
      s2_q     <= s1_q;
      s2_p     <= s1_p;
      s2_vel   <= s1_vel;
      s2_acc   <= s1_acc;
      s2_delta <= s1_delta;
      s2_lin   <= s1_m2 >>> F;
      s2_vel_r <= sat(BIG'(s1_vel) + BIG'(s1_m1 >>> F));
      s2_plo   <= plo;
      s2_phi   <= phi;
      // v*v - 2*a*(p - target) = v*v + 2*a*delta
      s2_disc  <= DSW'(s1_m2) + (DSW'(s1_m1) <<< 1);
    end
  end

  // ---- stage 3: combine halves, floor shift of the quadratic term
  logic signed [QW-1:0] qf;
  assign qf = (QW'(s2_phi) <<< W) + QW'(s2_plo);

  logic                  s3_valid;
  cams_pkg::cls_t        s3_cls;
  logic signed [W-1:0]   s3_t, s3_q, s3_p, s3_vel, s3_acc, s3_vel_r;
  logic signed [W:0]     s3_delta;
  logic signed [2*W:0]   s3_lin;
  logic signed [QW-1:0]  s3_quad;
  logic signed [DSW-1:0] s3_disc;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (en) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_cls   <= s2_cls;
      s3_t     <= s2_t;
      s3_q     <= s2_q;
      s3_p     <= s2_p;
      s3_vel   <= s2_vel;
      s3_acc   <= s2_acc;
      s3_vel_r <= s2_vel_r;
      s3_delta <= s2_delta;
      s3_lin   <= s2_lin;
      s3_quad  <= qf >>> (2 * F + 1);
      s3_disc  <= s2_disc;
    end
  end

  // ---- stage 4: position sum, pack the side payload
  logic                extrap3;
  logic [W-1:0]        pos_r;
  cams_pkg::cls_t      cls4;

  always_comb begin
    extrap3 = (s3_cls == cams_pkg::CLS_EXTRAP);
    pos_r   = sat(BIG'(s3_p) + BIG'(s3_lin) + BIG'(s3_quad));
    cls4    = (s3_cls == cams_pkg::CLS_QUAD && s3_disc[DSW-1]) ? cams_pkg::CLS_NEVER
                                                               : s3_cls;
  end

  logic              s4_valid;
  logic [XB-1:0]     s4_x;
  logic [SIDE_W-1:0] s4_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (en) begin
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_x    <= s3_disc[DSW-1] ? '0 : s3_disc[XB-1:0];
      s4_side <= {cls4,
                  extrap3 ? s3_q : s3_t,
                  extrap3 ? pos_r : s3_vel,
                  extrap3 ? s3_vel_r : s3_acc,
                  extrap3 ? {s3_acc[W-1], s3_acc} : s3_delta};
    end
  end

  logic              r_valid;
  logic [SW-1:0]     r_root;
  logic [SIDE_W-1:0] r_side;

  cams_sqrt_pipe #(
    .XB     (XB),
    .RW     (SW),
    .SIDE_W (SIDE_W)
  ) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s4_valid),
    .in_x      (s4_x),
    .in_side   (s4_side),
    .out_valid (r_valid),
    .out_root  (r_root),
    .out_side  (r_side)
  );

  // ---- divider operand stage: -v +/- s over a, or delta over v
  logic [CB-1:0]       r_cls_bits;
  cams_pkg::cls_t      r_cls;
  logic signed [W-1:0] r_x1, r_x2;
  logic signed [W:0]   r_x3;
  logic signed [NS-1:0] rs, nv, nplus, nminus;
  logic [NS-1:0]       mag_p, mag_m;
  logic [W:0]          d_mag, den_ext, den_abs;
  logic [W+1:0]        mag_a, mag_b;
  logic                num_sa, num_sb, den_s;

  // time word passes through in r_side untouched
  assign r_cls_bits = r_side[SIDE_W-1 -: CB];
  assign r_x1       = r_side[2*W+1 +: W];
  assign r_x2       = r_side[W+1 +: W];
  assign r_x3       = r_side[W:0];
  assign r_cls      = cams_pkg::cls_t'(r_cls_bits);

  always_comb begin
    rs     = NS'($signed({1'b0, r_root}));
    nv     = -NS'(r_x1);
    nplus  = nv + rs;
    nminus = nv - rs;
    mag_p  = nplus[NS-1] ? ~nplus + 1'b1 : nplus;
    mag_m  = nminus[NS-1] ? ~nminus + 1'b1 : nminus;
    d_mag  = r_x3[W] ? ~r_x3 + 1'b1 : r_x3;
    if (r_cls == cams_pkg::CLS_LINEAR) begin
      mag_a   = (W+2)'(d_mag);
      mag_b   = '0;
      num_sa  = r_x3[W];
      num_sb  = 1'b0;
      den_ext = {r_x1[W-1], r_x1};
    end else begin
      mag_a   = mag_p[W+1:0];
      mag_b   = mag_m[W+1:0];
      num_sa  = nplus[NS-1];
      num_sb  = nminus[NS-1];
      den_ext = {r_x2[W-1], r_x2};
    end
    den_s   = den_ext[W];
    den_abs = den_s ? ~den_ext + 1'b1 : den_ext;
  end

  logic               p1_valid;
  logic [NM-1:0]      p1_num_a, p1_num_b;
  logic [W-1:0]       p1_den;
  logic [SIDE2-1:0]   p1_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else if (en) begin
      p1_valid <= r_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_num_a <= NM'(mag_a) << F;
      p1_num_b <= NM'(mag_b) << F;
      p1_den   <= den_abs[W-1:0];
      p1_side  <= {num_sa ^ den_s, num_sb ^ den_s, r_side};
    end
  end

  logic             d_valid;
  logic [NM-1:0]    d_qa, d_qb;
  logic             d_ra_nz, d_rb_nz;
  logic [SIDE2-1:0] d_side;

  cams_div_pipe #(
    .NM     (NM),
    .DW     (W),
    .SIDE_W (SIDE2)
  ) u_div (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .in_valid     (p1_valid),
    .in_num_a     (p1_num_a),
    .in_num_b     (p1_num_b),
    .in_den       (p1_den),
    .in_side      (p1_side),
    .out_valid    (d_valid),
    .out_quo_a    (d_qa),
    .out_quo_b    (d_qb),
    .out_rem_a_nz (d_ra_nz),
    .out_rem_b_nz (d_rb_nz),
    .out_side     (d_side)
  );

  // ---- floor correction for negative quotients
  logic        sa, sb;
  logic [NM:0] qa_mag, qb_mag;

  always_comb begin
    sa     = d_side[SIDE2-1];
    sb     = d_side[SIDE2-2];
    qa_mag = {1'b0, d_qa} + (NM+1)'(sa && d_ra_nz);
    qb_mag = {1'b0, d_qb} + (NM+1)'(sb && d_rb_nz);
  end

  logic               p2_valid;
  logic signed [NM:0] p2_da, p2_db;
  logic [SIDE_W-1:0]  p2_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      p2_valid <= 1'b0;
    end else if (en) begin
      p2_valid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p2_da   <= sa ? ~qa_mag + 1'b1 : qa_mag;
      p2_db   <= sb ? ~qb_mag + 1'b1 : qb_mag;
      p2_side <= d_side[SIDE_W-1:0];
    end
  end

  // ---- root select
  logic [CB-1:0]       c_bits;
  cams_pkg::cls_t      c_cls;
  logic signed [W-1:0] c_tq, c_x1, c_x2;
  logic signed [W:0]   c_x3;
  logic signed [NM:0]  dt_sel;
  logic                reach_sel;

  assign {c_bits, c_tq, c_x1, c_x2, c_x3} = p2_side;
  assign c_cls = cams_pkg::cls_t'(c_bits);

  always_comb begin
    dt_sel    = '0;
    reach_sel = 1'b0;
    case (c_cls)
      cams_pkg::CLS_EXTRAP, cams_pkg::CLS_AT_TARGET: begin
        reach_sel = 1'b1;
      end
      cams_pkg::CLS_LINEAR: begin
        dt_sel    = p2_da;
        reach_sel = 1'b1;
      end
      cams_pkg::CLS_QUAD: begin
        // b is the root from -v - s, a the root from -v + s
        if (!p2_db[NM] && (p2_da[NM] || p2_db < p2_da)) begin
          dt_sel    = p2_db;
          reach_sel = 1'b1;
        end else if (!p2_da[NM]) begin
          dt_sel    = p2_da;
          reach_sel = 1'b1;
        end
      end
      default: begin
        reach_sel = 1'b0;
      end
    endcase
  end

  logic                p3_valid;
  logic                p3_extrap;
  logic                p3_reach;
  logic signed [NM:0]  p3_dt;
  logic signed [W-1:0] p3_tq, p3_x1, p3_x2, p3_x3;

  always_ff @(posedge clk) begin
    if (rst) begin
      p3_valid <= 1'b0;
    end else if (en) begin
      p3_valid <= p2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p3_extrap <= (c_cls == cams_pkg::CLS_EXTRAP);
      p3_reach  <= reach_sel;
      p3_dt     <= dt_sel;
      p3_tq     <= c_tq;
      p3_x1     <= c_x1;
      p3_x2     <= c_x2;
      p3_x3     <= c_x3[W-1:0];
    end
  end

  // ---- output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= p3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_time <= p3_reach ? sat(BIG'(p3_tq) + BIG'(p3_dt)) : '0;
      out_pos  <= p3_extrap ? p3_x1 : '0;
      out_vel  <= p3_extrap ? p3_x2 : '0;
      out_acc  <= p3_extrap ? p3_x3 : '0;
      reached  <= p3_reach;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/constant_accel_motion_solver.sv -----
// Top level of the constant-acceleration motion solver: tolerance register,
// front end, queue and math back end. Depends on cams_pkg and all cams_* modules.
//
//   channel  | handshake              | payload
//   ---------+------------------------+---------------------------------------
//   input    | in_valid / in_ready    | func, start_*, query_time, given_acc...
//   result   | out_valid / out_ready  | out_time, out_pos, out_vel, out_acc,
//            |                        | reached
//   config   | cfg_valid / cfg_ready  | cfg_data (tolerance)
//
// One beat per cycle sustained in and out while results are taken. Each beat passes
// through the front register and queue, four multiply stages, the square-root
// pipeline (WORD_BITS+1 stages), an operand register, the divider pipeline
// (WORD_BITS+FRAC_BITS+2 stages) and three final registers.
// Synchronous active-high reset empties all stages; tolerance resets to 1.
// A stalled result freezes the whole back end; the two-entry queue and the
// front register keep taking input beats until they fill.
`default_nettype none

module constant_accel_motion_solver #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [cams_pkg::TOL_BITS-1:0] cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          func,
  input  logic signed [WORD_BITS-1:0]   start_time,
  input  logic signed [WORD_BITS-1:0]   start_pos,
  input  logic signed [WORD_BITS-1:0]   start_vel,
  input  logic signed [WORD_BITS-1:0]   start_acc,
  input  logic signed [WORD_BITS-1:0]   query_time,
  input  logic                          use_given_acc,
  input  logic signed [WORD_BITS-1:0]   given_acc,
  input  logic signed [WORD_BITS-1:0]   target_pos,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [WORD_BITS-1:0]   out_time,
  output logic signed [WORD_BITS-1:0]   out_pos,
  output logic signed [WORD_BITS-1:0]   out_vel,
  output logic signed [WORD_BITS-1:0]   out_acc,
  output logic                          reached
);

  localparam int REC_W = 7 * WORD_BITS + 2;
  localparam int Q_W   = cams_pkg::CLS_BITS + REC_W;

  logic [cams_pkg::TOL_BITS-1:0] tolerance;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance <= cams_pkg::TOL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      tolerance <= cfg_data;
    end
  end

  logic             f_valid;
  logic             f_ready;
  cams_pkg::cls_t   f_cls;
  logic [REC_W-1:0] f_data;

  cams_front #(
    .W (WORD_BITS)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .func          (func),
    .start_time    (start_time),
    .start_pos     (start_pos),
    .start_vel     (start_vel),
    .start_acc     (start_acc),
    .query_time    (query_time),
    .use_given_acc (use_given_acc),
    .given_acc     (given_acc),
    .target_pos    (target_pos),
    .tol           (tolerance),
    .rec_valid     (f_valid),
    .rec_ready     (f_ready),
    .rec_cls       (f_cls),
    .rec_data      (f_data)
  );

  logic           q_valid;
  logic           q_ready;
  logic [Q_W-1:0] q_data;

  cams_fifo #(
    .WIDTH (Q_W)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  ({f_cls, f_data}),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_data)
  );

  cams_back #(
    .W (WORD_BITS),
    .F (FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (q_valid),
    .in_ready  (q_ready),
    .in_cls    (cams_pkg::cls_t'(q_data[Q_W-1:REC_W])),
    .in_data   (q_data[REC_W-1:0]),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_time  (out_time),
    .out_pos   (out_pos),
    .out_vel   (out_vel),
    .out_acc   (out_acc),
    .reached   (reached)
  );

  a_cfg_write: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready |=> tolerance == $past(cfg_data))
    else $error("tolerance not updated by config beat");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !reached |-> out_time == '0 && out_pos == '0 && out_vel == '0
                              && out_acc == '0)
    else $error("unreached result carries nonzero fields");

  a_queue_hold: assert property (@(posedge clk) disable iff (rst)
    q_valid && !q_ready |=> q_valid)
    else $error("queue dropped a waiting beat");

endmodule

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench for constant_accel_motion_solver: drives motion
// beats, predicts each result in wide integer math and checks every field.
// Depends on cams_pkg and the solver RTL.
`default_nettype none

module tb_top;

  localparam int WB = 32;
  localparam int FB = 16;
  localparam int LIMIT = 400000;
  localparam int DRAIN_CYCLES = 3 * WB + FB + 40;

  typedef logic signed [127:0] wide_t;
  localparam wide_t WMAX = 128'sh7fffffff;
  localparam wide_t WMIN = -128'sh80000000;

  typedef struct {
    logic func;
    logic signed [WB-1:0] st, sp, sv, sa, qt;
    logic ug;
    logic signed [WB-1:0] ga, tp;
  } motion_t;

  typedef struct {
    logic signed [WB-1:0] t, p, v, a;
    logic reached;
  } answer_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [cams_pkg::TOL_BITS-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  motion_t cur = '{default: '0};
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [WB-1:0] out_time, out_pos, out_vel, out_acc;
  logic reached;

  answer_t answers_q[$];
  logic [cams_pkg::TOL_BITS-1:0] tol = cams_pkg::TOL_RESET;
  int errors = 0;
  int cycles = 0;
  int n_extrap = 0, n_hit = 0, n_miss = 0;
  int burst_left = 0;
  int hold_req = 0;
  int hold_cnt = 0;
  int stall_pct = 0;

  constant_accel_motion_solver u_top (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .func(cur.func), .start_time(cur.st), .start_pos(cur.sp), .start_vel(cur.sv),
    .start_acc(cur.sa), .query_time(cur.qt), .use_given_acc(cur.ug),
    .given_acc(cur.ga), .target_pos(cur.tp),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_time(out_time), .out_pos(out_pos), .out_vel(out_vel), .out_acc(out_acc),
    .reached(reached)
  );

  always #10 clk = ~clk;

  // ---------------- kinematics predictor ----------------
  function automatic wide_t div_floor(wide_t n, wide_t d);
    wide_t q;
    q = n / d;
    if ((n % d) != 0 && ((n < 0) != (d < 0))) q = q - 1;
    return q;
  endfunction

  function automatic wide_t sqrt_floor(wide_t x);
    wide_t r, c;
    r = 0;
    for (int b = 40; b >= 0; b--) begin
      c = r | (wide_t'(1) << b);
      if (c * c <= x) r = c;
    end
    return r;
  endfunction

  function automatic logic signed [WB-1:0] clamp(wide_t x);
    if (x > WMAX) return WMAX[WB-1:0];
    if (x < WMIN) return WMIN[WB-1:0];
    return x[WB-1:0];
  endfunction

  function automatic wide_t absw(wide_t x);
    return x < 0 ? -x : x;
  endfunction

  function automatic answer_t solve_motion(motion_t m, logic [cams_pkg::TOL_BITS-1:0] eps);
    answer_t r;
    wide_t t, p, v, a, acc, dt, ad, delta, disc, s, dmax, dmin, e;
    r = '{default: '0};
    t = m.st; p = m.sp; v = m.sv; a = m.sa;
    e = wide_t'({1'b0, eps});
    if (m.func == cams_pkg::FUNC_EXTRAP) begin
      acc = m.ug ? wide_t'(m.ga) : a;
      dt = wide_t'(m.qt) - t;
      ad = acc * dt;
      r.t = m.qt;
      r.p = clamp(p + ((v * dt) >>> FB) + ((ad * dt) >>> (2 * FB + 1)));
      r.v = clamp(v + (ad >>> FB));
      r.a = acc[WB-1:0];
      r.reached = 1'b1;
    end else begin
      delta = wide_t'(m.tp) - p;
      if (absw(delta) <= e) begin
        r.t = m.st;
        r.reached = 1'b1;
      end else if (absw(a) <= e) begin
        if (absw(v) > e && ((delta > 0) == (v > 0))) begin
          r.t = clamp(t + div_floor(delta <<< FB, v));
          r.reached = 1'b1;
        end
      end else begin
        disc = v * v + 2 * a * delta;
        if (disc >= 0) begin
          s = sqrt_floor(disc);
          dmax = div_floor((-v + s) <<< FB, a);
          dmin = div_floor((-v - s) <<< FB, a);
          if (dmin >= 0 && (dmax < 0 || dmin < dmax)) begin
            r.t = clamp(t + dmin);
            r.reached = 1'b1;
          end else if (dmax >= 0) begin
            r.t = clamp(t + dmax);
            r.reached = 1'b1;
          end
        end
      end
    end
    return r;
  endfunction

  // ---------------- scoreboard: one process, push then pop ----------------
  always @(posedge clk) begin
    answer_t want;
    cycles <= cycles + 1;
    if (!rst && in_valid && in_ready) begin
      want = solve_motion(cur, tol);
      answers_q.push_back(want);
      if (cur.func == cams_pkg::FUNC_EXTRAP) n_extrap++;
      else if (want.reached) n_hit++;
      else n_miss++;
    end
    if (!rst && out_valid && out_ready) begin
      if (answers_q.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
      end else begin
        want = answers_q.pop_front();
        if (out_time !== want.t) begin
          $error("out_time exp %0d got %0d", want.t, out_time); errors++;
        end
        if (out_pos !== want.p) begin
          $error("out_pos exp %0d got %0d", want.p, out_pos); errors++;
        end
        if (out_vel !== want.v) begin
          $error("out_vel exp %0d got %0d", want.v, out_vel); errors++;
        end
        if (out_acc !== want.a) begin
          $error("out_acc exp %0d got %0d", want.a, out_acc); errors++;
        end
        if (reached !== want.reached) begin
          $error("reached exp %0d got %0d", want.reached, reached); errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > LIMIT) begin
      $display("constant_accel_motion_solver test failed");
      $finish;
    end
  end

  // receiver: random stall rate that is redrawn during the run, plus long hold-offs
  always @(negedge clk) begin
    if (hold_req > 0) begin
      hold_cnt = hold_req;
      hold_req = 0;
    end
    if (cycles % 64 == 0) stall_pct = $urandom_range(0, 3) * 25;
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_ready = 1'b0;
    end else begin
      out_ready = ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // ---------------- driving ----------------
  task automatic send_motion(motion_t m);
    if (burst_left == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(0, 6)) @(negedge clk);
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    cur = m;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic wait_idle();
    while (answers_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_tolerance(logic [cams_pkg::TOL_BITS-1:0] val);
    wait_idle();
    cfg_data = val;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    tol = val;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic int srnd(int r);
    return int'($urandom_range(0, 2 * r)) - r;
  endfunction

  function automatic motion_t mk_solve(int st, int sp, int sv, int sa, int tp);
    motion_t m;
    m = '{default: '0};
    m.func = cams_pkg::FUNC_SOLVE;
    m.st = st; m.sp = sp; m.sv = sv; m.sa = sa; m.tp = tp;
    m.qt = $urandom; m.ga = $urandom; m.ug = 1'($urandom);
    return m;
  endfunction

  function automatic motion_t mk_extrap(int st, int sp, int sv, int sa, int qt,
                                        logic ug, int ga);
    motion_t m;
    m = '{default: '0};
    m.func = cams_pkg::FUNC_EXTRAP;
    m.st = st; m.sp = sp; m.sv = sv; m.sa = sa; m.qt = qt; m.ug = ug; m.ga = ga;
    m.tp = $urandom;
    return m;
  endfunction

  function automatic motion_t rnd_noise();
    motion_t m;
    m.func = 1'($urandom); m.ug = 1'($urandom);
    m.st = $urandom; m.sp = $urandom; m.sv = $urandom; m.sa = $urandom;
    m.qt = $urandom; m.ga = $urandom; m.tp = $urandom;
    return m;
  endfunction

  // well-formed motion: modest magnitudes so targets are often reached
  function automatic motion_t rnd_motion();
    motion_t m;
    int st, sp;
    st = srnd(1 << 22);
    sp = srnd(1 << 24);
    case ($urandom_range(0, 4))
      0: m = mk_solve(st, sp, srnd(1 << 20), srnd(int'(tol)), sp + srnd(1 << 22));
      1: m = mk_solve(st, sp, srnd(1 << 20), srnd(1 << 18), sp + srnd(1 << 24));
      2: m = mk_solve(st, sp, srnd(1 << 20), srnd(1 << 18), sp + srnd(int'(tol) + 2));
      default: m = mk_extrap(st, sp, srnd(1 << 22), srnd(1 << 20),
                             st + srnd(1 << 19), 1'($urandom), srnd(1 << 20));
    endcase
    return m;
  endfunction

  // ---------------- tests ----------------
  task automatic test_directed();
    int mx, mn;
    mx = 32'h7fffffff;
    mn = 32'h80000000;
    // extremes, saturation both ways, given acceleration
    send_motion(mk_extrap(mn, mx, mx, mx, mx, 1'b0, 0));
    send_motion(mk_extrap(mx, mn, mn, mn, mn, 1'b0, 0));
    send_motion(mk_extrap(0, 0, 0, 0, 0, 1'b1, mx));
    send_motion(mk_extrap(65536, 100, -65536, 0, 3 * 65536, 1'b1, mn));
    send_motion(mk_extrap(0, -5, 3, -7, -65536, 1'b0, 1));
    // already at target, within and just past tolerance
    send_motion(mk_solve(1234, 5000, 0, 0, 5001));
    send_motion(mk_solve(1234, 5000, 0, 0, 5002));
    // zero acceleration: toward, away, stopped
    send_motion(mk_solve(0, 0, 65536, 1, 10 * 65536));
    send_motion(mk_solve(0, 0, -65536, 0, 10 * 65536));
    send_motion(mk_solve(0, 0, 1, 0, 10 * 65536));
    // quadratic: reached, negative discriminant, both roots behind, one root behind
    send_motion(mk_solve(0, 0, 0, 2 * 65536, 4 * 65536));
    send_motion(mk_solve(0, 0, 0, -2 * 65536, 4 * 65536));
    send_motion(mk_solve(0, 0, 5 * 65536, 65536, -65536));
    send_motion(mk_solve(0, 0, -5 * 65536, 65536, 65536));
    // reach time overflow saturates and stays reached, plus solves with extreme operands
    send_motion(mk_solve(mx, 0, 1 << 16, 0, 1 << 30));
    send_motion(mk_solve(mn, mn, mx, 0, mx));
    send_motion(mk_solve(mx, mx, mn, mn, mn));
    send_motion(mk_solve(0, mx, mn, mx, mn));
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++)
      send_motion(($urandom_range(0, 4) == 0) ? rnd_noise() : rnd_motion());
  endtask

  // more beats than the pipeline, queue and front register can hold
  task automatic test_backpressure();
    hold_req = 600;
    for (int i = 0; i < 120; i++) send_motion(rnd_motion());
    wait_idle();
  endtask

  task automatic test_tolerance_sweep();
    write_tolerance(16'd0);
    test_random(120);
    write_tolerance(16'hffff);
    test_random(120);
    write_tolerance(16'($urandom_range(2, 4000)));
    test_random(120);
    write_tolerance(cams_pkg::TOL_RESET);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_random(100);
    test_backpressure();
    test_tolerance_sweep();
    test_random(40);
    wait_idle();
    $display("covered %0d extrapolations, %0d reached solves, %0d unreached solves",
             n_extrap, n_hit, n_miss);
    $display("tolerance swept over 0, max, random and reset value with back-pressure");
    if (errors == 0)
      $display("constant_accel_motion_solver test passed");
    else
      $display("constant_accel_motion_solver test failed");
    $finish;
  end

endmodule

`default_nettype wire

// ----- constant_accel_motion_solver.f -----
hdl/cams_pkg.sv
hdl/cams_fifo.sv
hdl/cams_front.sv
hdl/cams_sqrt_pipe.sv
hdl/cams_div_pipe.sv
hdl/cams_back.sv
hdl/constant_accel_motion_solver.sv
tb/sv/tb_top.sv
